@@ src/event_stream_data_parser_top_defines.svh @@
// ----------------------------------------------------------------------------
// Event stream data parser - assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef EVENT_STREAM_DATA_PARSER_TOP_DEFINES_SVH
`define EVENT_STREAM_DATA_PARSER_TOP_DEFINES_SVH

// clocked assertion, off while reset is low
`define ESDP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("esdp check failed");

// clocked assertion, also checked during reset
`define ESDP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("esdp reset check failed");

`endif

@@ src/esdp_pkg.sv @@
// ----------------------------------------------------------------------------
// Event stream data parser - package
// Codes, characters and match texts shared by the parser files.
// ----------------------------------------------------------------------------
`default_nettype none

package esdp_pkg;

  localparam int LINE_COUNT_BITS_DEF = 16;
  localparam logic [15:0] LINE_LIMIT_RESET = 16'hFFFF;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;

  localparam logic [2:0] PFX_LEN  = 3'd5;
  localparam logic [2:0] DONE_LEN = 3'd6;

  localparam logic OP_BYTE   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_EVENT_END = 2'd1,
    KIND_DONE      = 2'd2,
    KIND_OVERFLOW  = 2'd3
  } kind_t;

  // "data:"
  function automatic logic [7:0] pfx_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h64;
      3'd1: c = 8'h61;
      3'd2: c = 8'h74;
      3'd3: c = 8'h61;
      3'd4: c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "[DONE]"
  function automatic logic [7:0] done_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h5B;
      3'd1: c = 8'h44;
      3'd2: c = 8'h4F;
      3'd3: c = 8'h4E;
      3'd4: c = 8'h45;
      3'd5: c = 8'h5D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/esdp_in_if.sv @@
// ----------------------------------------------------------------------------
// Event stream data parser - input channel
// Valid/ready channel carrying one stream byte or end-of-stream request.
// ----------------------------------------------------------------------------
`default_nettype none

interface esdp_in_if import esdp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_byte;

  modport source (output valid, output op, output in_byte, input ready);
  modport sink   (input valid, input op, input in_byte, output ready);
endinterface

`default_nettype wire

@@ src/esdp_out_if.sv @@
// ----------------------------------------------------------------------------
// Event stream data parser - result channel
// Valid/ready channel carrying one parser result.
// ----------------------------------------------------------------------------
`default_nettype none

interface esdp_out_if import esdp_pkg::*; ();
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

`default_nettype wire

@@ src/event_stream_data_parser_top.sv @@
// ----------------------------------------------------------------------------
// Event stream data parser - top level
// Splits a text event stream into lines and forwards the data line values.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : one request per stream byte (op = 0) or end of stream (op = 1).
//   out_req : payload bytes, event end, done and overflow results; last marks
//             the final result of one request.
//   cfg_we / cfg_wdata : line_limit, written while the block is idle.
// Each request is parsed in the cycle it is accepted and gives 0 to 8
// results, loaded into a result buffer that drains one result per cycle
// into the output register while the receiver is ready; results pass the
// buffer and then the output register. A request with at most one result
// sustains one request per cycle while the receiver is ready; one with more
// holds in_req until the single buffer read port has handed out its last.
// A request is taken while the output register holds a result, as long as
// the buffer is empty or hands over its last result in that cycle; when the
// receiver stalls, the output holds and in_req.ready drops once the buffer
// is occupied. Reset clears the line state, the event flag, the stop flag
// and all pending results, and sets line_limit to 65535. Once stopped, the
// block keeps accepting requests and gives no result.
// ----------------------------------------------------------------------------
`default_nettype none

module event_stream_data_parser_top import esdp_pkg::*; #(
  parameter int LINE_COUNT_BITS = LINE_COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  esdp_in_if.sink          in_req,
  esdp_out_if.source       out_req,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  localparam int CNT_W = (LINE_COUNT_BITS > 16) ? LINE_COUNT_BITS : 16;

  typedef enum logic [2:0] {
    PH_PREFIX     = 3'd0,
    PH_COLON      = 3'd1,
    PH_DONE_WATCH = 3'd2,
    PH_IGNORE     = 3'd3,
    PH_LONE_CR    = 3'd4,
    PH_PLAIN      = 3'd5
  } phase_t;

  phase_t                     phase_r, phase_nxt;
  logic [2:0]                 prefix_pos_r, prefix_pos_nxt;
  logic [2:0]                 done_len_r, done_len_nxt;
  logic                       cr_held_r, cr_held_nxt;
  logic [LINE_COUNT_BITS-1:0] line_bytes_r, line_bytes_nxt;
  logic                       event_open_r, event_open_nxt;
  logic                       stopped_r, stopped_nxt;
  logic [15:0]                limit_r;

  logic [2:0] rel_n_nxt, rel_dl_nxt;
  kind_t      tail_k_nxt [2];
  logic [7:0] tail_b_nxt [2];
  logic [1:0] tail_n_nxt;
  logic       do_end, do_line, do_value, do_plain, overflow;

  logic [2:0] buf_rel_n_r, buf_rel_dl_r;
  kind_t      buf_tk_r [2];
  logic [7:0] buf_tb_r [2];
  logic [3:0] buf_tot_r, buf_pos_r, buf_diff;
  logic       buf_v, move, sel_last, accept;
  kind_t      sel_kind;
  logic [7:0] sel_byte;

  logic       out_valid_r;
  kind_t      out_kind_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  assign overflow = (CNT_W'(line_bytes_r) >= CNT_W'(limit_r)) || (&line_bytes_r);

  always_comb begin
    phase_nxt      = phase_r;
    prefix_pos_nxt = prefix_pos_r;
    done_len_nxt   = done_len_r;
    cr_held_nxt    = cr_held_r;
    line_bytes_nxt = line_bytes_r;
    event_open_nxt = event_open_r;
    stopped_nxt    = stopped_r;
    rel_n_nxt      = '0;
    rel_dl_nxt     = '0;
    tail_n_nxt     = '0;
    tail_k_nxt[0]  = KIND_PAYLOAD;
    tail_k_nxt[1]  = KIND_PAYLOAD;
    tail_b_nxt[0]  = '0;
    tail_b_nxt[1]  = '0;
    do_end         = 1'b0;
    do_line        = 1'b0;
    do_value       = 1'b0;
    do_plain       = 1'b0;

    if (!stopped_r) begin
      if (in_req.op == OP_FINISH) begin
        do_end = (line_bytes_r != '0);
      end else if (in_req.in_byte == CH_LF) begin
        do_end = 1'b1;
      end else if (overflow) begin
        tail_k_nxt[0]  = KIND_OVERFLOW;
        tail_n_nxt     = 2'd1;
        line_bytes_nxt = '0;
        phase_nxt      = PH_PREFIX;
        prefix_pos_nxt = '0;
        done_len_nxt   = '0;
        cr_held_nxt    = 1'b0;
        stopped_nxt    = 1'b1;
      end else begin
        do_line = 1'b1;
      end
    end

    // end of line
    if (do_end) begin
      case (phase_r)
        PH_PREFIX: begin
          if (line_bytes_r == '0 && event_open_r) begin
            tail_k_nxt[0]  = KIND_EVENT_END;
            tail_n_nxt     = 2'd1;
            event_open_nxt = 1'b0;
          end
        end
        PH_LONE_CR: begin
          if (event_open_r) begin
            tail_k_nxt[0]  = KIND_EVENT_END;
            tail_n_nxt     = 2'd1;
            event_open_nxt = 1'b0;
          end
        end
        PH_COLON, PH_PLAIN: begin
          event_open_nxt = 1'b1;
        end
        PH_DONE_WATCH: begin
          if (done_len_r == DONE_LEN) begin
            tail_k_nxt[0] = KIND_DONE;
            tail_n_nxt    = 2'd1;
            stopped_nxt   = 1'b1;
          end else begin
            rel_n_nxt      = done_len_r;
            rel_dl_nxt     = done_len_r;
            event_open_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
      line_bytes_nxt = '0;
      phase_nxt      = PH_PREFIX;
      prefix_pos_nxt = '0;
      done_len_nxt   = '0;
      cr_held_nxt    = 1'b0;
    end

    // end of stream: flush the open event and stop
    if (!stopped_r && in_req.op == OP_FINISH) begin
      if (!stopped_nxt && event_open_nxt) begin
        tail_k_nxt[tail_n_nxt[0]] = KIND_EVENT_END;
        tail_b_nxt[tail_n_nxt[0]] = '0;
        tail_n_nxt                = tail_n_nxt + 2'd1;
        event_open_nxt            = 1'b0;
      end
      stopped_nxt = 1'b1;
    end

    if (do_line) begin
      line_bytes_nxt = line_bytes_r + 1'b1;
      case (phase_r)
        PH_PREFIX: begin
          if (in_req.in_byte == pfx_char(prefix_pos_r)) begin
            prefix_pos_nxt = prefix_pos_r + 3'd1;
            if (prefix_pos_nxt == PFX_LEN) begin
              phase_nxt = PH_COLON;
            end
          end else if (line_bytes_r == '0 && in_req.in_byte == CH_CR) begin
            phase_nxt = PH_LONE_CR;
          end else begin
            phase_nxt = PH_IGNORE;
          end
        end
        PH_COLON: begin
          phase_nxt = event_open_r ? PH_PLAIN : PH_DONE_WATCH;
          do_value  = (in_req.in_byte != CH_SP);
        end
        PH_DONE_WATCH, PH_PLAIN: begin
          do_value = 1'b1;
        end
        PH_LONE_CR: begin
          phase_nxt = PH_IGNORE;
        end
        default: begin
        end
      endcase
    end

    if (do_value) begin
      if (phase_nxt != PH_DONE_WATCH) begin
        do_plain = 1'b1;
      end else if (cr_held_r) begin
        rel_n_nxt    = done_len_r + 3'd1;
        rel_dl_nxt   = done_len_r;
        done_len_nxt = '0;
        cr_held_nxt  = 1'b0;
        phase_nxt    = PH_PLAIN;
        do_plain     = 1'b1;
      end else if (done_len_r < DONE_LEN && in_req.in_byte == done_char(done_len_r)) begin
        done_len_nxt = done_len_r + 3'd1;
      end else if (in_req.in_byte == CH_CR) begin
        cr_held_nxt = 1'b1;
      end else begin
        rel_n_nxt    = done_len_r;
        rel_dl_nxt   = done_len_r;
        done_len_nxt = '0;
        phase_nxt    = PH_PLAIN;
        do_plain     = 1'b1;
      end
    end

    if (do_plain) begin
      if (cr_held_nxt) begin
        tail_k_nxt[tail_n_nxt[0]] = KIND_PAYLOAD;
        tail_b_nxt[tail_n_nxt[0]] = CH_CR;
        tail_n_nxt                = tail_n_nxt + 2'd1;
        cr_held_nxt               = 1'b0;
      end
      if (in_req.in_byte == CH_CR) begin
        cr_held_nxt = 1'b1;
      end else begin
        tail_k_nxt[tail_n_nxt[0]] = KIND_PAYLOAD;
        tail_b_nxt[tail_n_nxt[0]] = in_req.in_byte;
        tail_n_nxt                = tail_n_nxt + 2'd1;
      end
    end
  end

  // result buffer read side
  assign buf_v    = (buf_pos_r != buf_tot_r);
  assign buf_diff = buf_pos_r - {1'b0, buf_rel_n_r};
  assign sel_last = ((buf_pos_r + 4'd1) == buf_tot_r);
  assign move     = buf_v && (!out_valid_r || out_req.ready);

  always_comb begin
    if (buf_pos_r < {1'b0, buf_rel_n_r}) begin
      sel_kind = KIND_PAYLOAD;
      sel_byte = (buf_pos_r < {1'b0, buf_rel_dl_r}) ? done_char(buf_pos_r[2:0]) : CH_CR;
    end else begin
      sel_kind = buf_tk_r[buf_diff[0]];
      sel_byte = buf_tb_r[buf_diff[0]];
    end
  end

  assign in_req.ready = !buf_v || (move && sel_last);
  assign accept       = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_PREFIX;
      prefix_pos_r <= '0;
      done_len_r   <= '0;
      cr_held_r    <= 1'b0;
      line_bytes_r <= '0;
      event_open_r <= 1'b0;
      stopped_r    <= 1'b0;
      limit_r      <= LINE_LIMIT_RESET;
      buf_tot_r    <= '0;
      buf_pos_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (accept) begin
        phase_r      <= phase_nxt;
        prefix_pos_r <= prefix_pos_nxt;
        done_len_r   <= done_len_nxt;
        cr_held_r    <= cr_held_nxt;
        line_bytes_r <= line_bytes_nxt;
        event_open_r <= event_open_nxt;
        stopped_r    <= stopped_nxt;
        buf_tot_r    <= {1'b0, rel_n_nxt} + {2'b00, tail_n_nxt};
        buf_pos_r    <= '0;
      end else if (move) begin
        buf_pos_r <= buf_pos_r + 4'd1;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_req.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_rel_n_r  <= rel_n_nxt;
      buf_rel_dl_r <= rel_dl_nxt;
      buf_tk_r[0]  <= tail_k_nxt[0];
      buf_tk_r[1]  <= tail_k_nxt[1];
      buf_tb_r[0]  <= tail_b_nxt[0];
      buf_tb_r[1]  <= tail_b_nxt[1];
    end
    if (move) begin
      out_kind_r <= sel_kind;
      out_byte_r <= sel_byte;
      out_last_r <= sel_last;
    end
  end

  assign out_req.valid    = out_valid_r;
  assign out_req.kind     = out_kind_r;
  assign out_req.out_byte = out_byte_r;
  assign out_req.last     = out_last_r;

endmodule

`default_nettype wire

@@ src/esdp_chk.sv @@
// ----------------------------------------------------------------------------
// Event stream data parser - port checker
// Watches the top level channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "event_stream_data_parser_top_defines.svh"

module esdp_chk import esdp_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire kind_t      out_kind,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  logic        out_stall;
  logic        out_marker;
  logic [10:0] out_word;

  assign out_stall  = out_valid && !out_ready;
  assign out_marker = out_valid && (out_kind != KIND_PAYLOAD);
  assign out_word   = {out_kind, out_byte, out_last};

  `ESDP_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid)
  `ESDP_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_word))
  `ESDP_ASSERT(a_burst_blocks, clk, rst_n, out_stall && !out_last |-> !in_ready)
  `ESDP_ASSERT(a_marker_last, clk, rst_n, out_marker |-> out_last && out_byte == 8'd0)

endmodule

bind event_stream_data_parser_top esdp_chk u_esdp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_req.ready),
  .out_valid (out_req.valid),
  .out_ready (out_req.ready),
  .out_kind  (out_req.kind),
  .out_byte  (out_req.out_byte),
  .out_last  (out_req.last)
);

`default_nettype wire

@@ dv/event_stream_data_parser_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Event stream data parser - testbench
// Sends a byte stream of data lines, noise lines, blank lines and near misses
// of the done marker. A line parser in the bench predicts every result, and
// each result is checked in order. The receiver and sender idle in bursts.
// The line limit changes between phases. One stop condition ends each run.
// ----------------------------------------------------------------------------

module event_stream_data_parser_top_tb;
  import esdp_pkg::*;

  localparam int unsigned LINE_MAX = (1 << LINE_COUNT_BITS_DEF) - 1;
  localparam int QUIET_LIMIT = 1000;
  localparam logic [7:0] DATA_TAG [5] = '{8'h64, 8'h61, 8'h74, 8'h61, 8'h3A};
  localparam logic [7:0] DONE_TAG [6] = '{8'h5B, 8'h44, 8'h4F, 8'h4E, 8'h45, 8'h5D};
  localparam logic [7:0] CH_FILL = 8'h58;
  localparam logic [7:0] CH_BRACE = 8'h7B;

  typedef enum logic [2:0] {
    PH_PREFIX  = 3'd0,
    PH_COLON   = 3'd1,
    PH_WATCH   = 3'd2,
    PH_SKIP    = 3'd3,
    PH_LONE_CR = 3'd4,
    PH_PLAIN   = 3'd5
  } phase_t;

  typedef enum {END_FINISH, END_DONE, END_OVERFLOW} ending_t;

  typedef struct {
    logic       op;
    logic [7:0] value;
  } request_t;

  typedef struct {
    kind_t      kind;
    logic [7:0] value;
    logic       last;
  } result_t;

  typedef logic [7:0] text_t[$];

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  esdp_in_if  in_ch ();
  esdp_out_if out_ch ();

  event_stream_data_parser_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_ch),
    .out_req  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // line parser state
  logic [15:0] line_cap;
  int unsigned line_fill;
  phase_t      phase;
  int          pfx_pos;
  logic [7:0]  held [7];
  int          held_n;
  bit          event_open;
  bit          halted;
  int          produced;

  request_t    pending [$];
  result_t     results_due [$];

  bit          stream_open;
  int          queued_total;
  int          requests_taken;
  int          idle_requests;
  int          results_checked;
  int          kind_tally [4];
  int          mismatches;
  int          limit_writes;
  int          send_gap;
  int          stall_left;
  int          quiet_cycles;
  logic [31:0] cyc_count = '0;
  logic        calm_tail;
  logic        long_hold;
  request_t    req;
  result_t     want;
  ending_t     ending;

  wire bursty = !calm_tail && (cyc_count[8:7] != 2'b11);

  function automatic void push_result(input kind_t kind, input logic [7:0] value);
    if (produced >= 8) return;
    results_due.push_back('{kind: kind, value: value, last: 1'b0});
    produced++;
  endfunction

  function automatic void release_held(input int n);
    for (int i = 0; i < n && i < 7; i++) push_result(KIND_PAYLOAD, held[i]);
  endfunction

  function automatic void close_event();
    if (event_open) begin
      push_result(KIND_EVENT_END, 8'h00);
      event_open = 1'b0;
    end
  endfunction

  function automatic void reset_line();
    line_fill = 0;
    phase = PH_PREFIX;
    pfx_pos = 0;
    held_n = 0;
  endfunction

  function automatic void plain_value_byte(input logic [7:0] b);
    if (held_n > 0) begin
      push_result(KIND_PAYLOAD, CH_CR);
      held_n = 0;
    end
    if (b == CH_CR) begin
      held[0] = b;
      held_n = 1;
    end else begin
      push_result(KIND_PAYLOAD, b);
    end
  endfunction

  function automatic void value_char(input logic [7:0] b);
    int n;
    n = (held_n > 7) ? 7 : held_n;
    if (phase != PH_WATCH) begin
      plain_value_byte(b);
    end else if (n > 0 && held[n-1] == CH_CR) begin
      release_held(n);
      held_n = 0;
      phase = PH_PLAIN;
      plain_value_byte(b);
    end else if (n < 6 && b == DONE_TAG[n]) begin
      held[n] = b;
      held_n = n + 1;
    end else if (b == CH_CR && n < 7) begin
      held[n] = b;
      held_n = n + 1;
    end else begin
      release_held(n);
      held_n = 0;
      phase = PH_PLAIN;
      plain_value_byte(b);
    end
  endfunction

  function automatic void finish_line();
    int n;
    n = (held_n > 7) ? 7 : held_n;
    case (phase)
      PH_PREFIX: if (line_fill == 0) close_event();
      PH_LONE_CR: close_event();
      PH_COLON, PH_PLAIN: event_open = 1'b1;
      PH_WATCH: begin
        if (n > 0 && held[n-1] == CH_CR) n--;
        if (n == 6) begin
          push_result(KIND_DONE, 8'h00);
          halted = 1'b1;
        end else begin
          release_held(n);
          event_open = 1'b1;
        end
      end
      default: ;
    endcase
    reset_line();
  endfunction

  function automatic void line_char(input logic [7:0] b);
    int unsigned prior;
    prior = line_fill;
    line_fill = prior + 1;
    case (phase)
      PH_PREFIX: begin
        if (pfx_pos < 5 && b == DATA_TAG[pfx_pos]) begin
          pfx_pos++;
          if (pfx_pos >= 5) phase = PH_COLON;
        end else if (prior == 0 && b == CH_CR) begin
          phase = PH_LONE_CR;
        end else begin
          phase = PH_SKIP;
        end
      end
      PH_COLON: begin
        phase = event_open ? PH_PLAIN : PH_WATCH;
        if (b != CH_SP) value_char(b);
      end
      PH_WATCH, PH_PLAIN: value_char(b);
      PH_LONE_CR: phase = PH_SKIP;
      default: ;
    endcase
  endfunction

  function automatic void parse_request(input logic op, input logic [7:0] b);
    produced = 0;
    if (halted) return;
    if (op == OP_FINISH) begin
      if (line_fill > 0) finish_line();
      if (!halted) close_event();
      halted = 1'b1;
    end else if (b == CH_LF) begin
      finish_line();
    end else if (line_fill >= line_cap || line_fill >= LINE_MAX) begin
      push_result(KIND_OVERFLOW, 8'h00);
      reset_line();
      halted = 1'b1;
    end else begin
      line_char(b);
    end
    if (produced > 0) results_due[results_due.size()-1].last = 1'b1;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) cyc_count <= cyc_count + 1;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (halted) idle_requests++;
        parse_request(in_ch.op, in_ch.in_byte);
        requests_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (bursty && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 16);
          in_ch.valid <= 1'b0;
        end else if (pending.size() > 0) begin
          req = pending.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.op <= req.op;
          in_ch.in_byte <= req.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || long_hold) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (bursty && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (results_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result kind %0d byte %02h last %0b",
                                out_ch.kind, out_ch.out_byte, out_ch.last));
      end else begin
        want = results_due.pop_front();
        kind_tally[want.kind]++;
        if (out_ch.kind !== want.kind || out_ch.out_byte !== want.value ||
            out_ch.last !== want.last)
          note_mismatch($sformatf(
            "expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
            want.kind, want.value, want.last, out_ch.kind, out_ch.out_byte, out_ch.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, results_due.size());
      $display("event_stream_data_parser_top_tb failed");
      $finish;
    end
  end

  // hold the receiver off long enough to back up the input
  initial begin
    long_hold = 1'b0;
    wait (requests_taken >= 150);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (90) @(posedge clk);
    long_hold <= 1'b0;
  end

  task automatic push_byte(input logic [7:0] b);
    pending.push_back('{op: OP_BYTE, value: b});
    queued_total++;
  endtask

  task automatic push_finish();
    pending.push_back('{op: OP_FINISH, value: 8'($urandom_range(0, 255))});
    queued_total++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_line(input text_t line);
    foreach (line[i]) push_byte(line[i]);
    push_byte(CH_LF);
  endtask

  function automatic logic [7:0] pick_text_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = CH_CR;
      1: b = CH_SP;
      2: b = DONE_TAG[$urandom_range(0, 5)];
      default: begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_LF) b = 8'hA5;
      end
    endcase
    return b;
  endfunction

  function automatic bit is_done_line(input text_t line);
    int at;
    int stop;
    at = (line.size() > 5 && line[5] == CH_SP) ? 6 : 5;
    stop = line.size();
    if (stop > at && line[stop-1] == CH_CR) stop--;
    if (stop - at != 6) return 1'b0;
    for (int i = 0; i < 6; i++) if (line[at+i] != DONE_TAG[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic gen_data_line();
    text_t line;
    int room;
    int k;
    int n;
    line = {};
    for (int i = 0; i < 5; i++) line.push_back(DATA_TAG[i]);
    if ($urandom_range(0, 1)) line.push_back(CH_SP);
    room = int'(line_cap) - line.size();
    n = 0;
    case ($urandom_range(0, 3))
      0: begin
        k = $urandom_range(0, 1) ? 6 : $urandom_range(1, 5);
        for (int i = 0; i < k; i++) line.push_back(DONE_TAG[i]);
        if ($urandom_range(0, 1)) line.push_back(CH_CR);
        n = $urandom_range(0, 2);
      end
      1: begin
        repeat ($urandom_range(1, 6)) begin
          line.push_back(pick_text_byte());
          line.push_back(CH_CR);
        end
      end
      default: begin
        if ($urandom_range(0, 7) == 0 && room <= 100) n = room;
        else n = $urandom_range(0, (room < 12) ? room : 12);
      end
    endcase
    repeat (n) line.push_back(pick_text_byte());
    if ($urandom_range(0, 3) == 0) line.push_back(CH_CR);
    while (line.size() > line_cap) void'(line.pop_back());
    // keep the done marker for events that already carry data
    if (!stream_open && is_done_line(line)) line[5] = CH_BRACE;
    push_line(line);
    stream_open = 1'b1;
  endtask

  task automatic gen_noise_line();
    text_t line;
    int k;
    logic [7:0] b;
    line = {};
    k = $urandom_range(0, 4);
    for (int i = 0; i < k; i++) line.push_back(DATA_TAG[i]);
    b = pick_text_byte();
    if (b == DATA_TAG[k]) b = CH_FILL;
    line.push_back(b);
    repeat ($urandom_range(0, 8)) line.push_back(pick_text_byte());
    while (line.size() > line_cap) void'(line.pop_back());
    if (line.size() == 1 && line[0] == CH_CR) line[0] = CH_FILL;
    push_line(line);
  endtask

  task automatic gen_blank();
    if ($urandom_range(0, 1)) push_byte(CH_CR);
    push_byte(CH_LF);
    stream_open = 1'b0;
  endtask

  task automatic gen_event();
    repeat ($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 3)) begin
      if ($urandom_range(0, 3) == 0) gen_noise_line();
      gen_data_line();
    end
    if ($urandom_range(0, 5) == 0) gen_noise_line();
    gen_blank();
    if ($urandom_range(0, 5) == 0) gen_blank();
  endtask

  task automatic run_random(input int n);
    int goal;
    goal = queued_total + n;
    while (queued_total < goal) gen_event();
  endtask

  task automatic drain();
    while (pending.size() != 0 || in_ch.valid || results_due.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    line_cap = v;
    limit_writes++;
  endtask

  initial begin
    text_t line;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_BYTE;
    in_ch.in_byte = '0;
    out_ch.ready = 1'b0;
    calm_tail = 1'b0;
    line_cap = LINE_LIMIT_RESET;
    foreach (held[i]) held[i] = 8'h00;
    reset_line();
    event_open = 1'b0;
    halted = 1'b0;
    stream_open = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    write_limit(16'd1);
    push_byte(CH_LF);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte(8'hFF);
    push_byte(CH_LF);
    drain();

    write_limit(16'hFFFF);
    push_text("data:\n");
    push_text("\r\n");
    push_text("data: [DON\r\n");
    push_text("\n");
    run_random(75);
    drain();

    write_limit(16'($urandom_range(12, 96)));
    run_random(85);
    drain();

    write_limit(16'd12);
    run_random(75);
    drain();

    calm_tail <= 1'b1;
    write_limit(16'($urandom_range(12, 48)));
    run_random(65);
    ending = ending_t'($urandom_range(0, 2));
    case (ending)
      END_FINISH: begin
        if ($urandom_range(0, 1)) begin
          push_text("data:");
          repeat ($urandom_range(1, 5)) push_byte(pick_text_byte());
        end
        push_finish();
      end
      END_DONE: begin
        if (stream_open) gen_blank();
        line = {};
        for (int i = 0; i < 5; i++) line.push_back(DATA_TAG[i]);
        if ($urandom_range(0, 1)) line.push_back(CH_SP);
        for (int i = 0; i < 6; i++) line.push_back(DONE_TAG[i]);
        if ($urandom_range(0, 1)) line.push_back(CH_CR);
        push_line(line);
      end
      default: begin
        push_text("data:");
        repeat (int'(line_cap) - 4) push_byte(pick_text_byte());
      end
    endcase
    // stopped: the rest must give nothing
    repeat (3) push_byte(pick_text_byte());
    push_byte(CH_LF);
    push_finish();
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d requests (%0d after stop), %0d results: %0d payload, %0d event end",
             requests_taken, idle_requests, results_checked,
             kind_tally[KIND_PAYLOAD], kind_tally[KIND_EVENT_END]);
    $display("%0d line limit writes, stream stopped by %s (done %0d, overflow %0d)",
             limit_writes, ending.name(), kind_tally[KIND_DONE], kind_tally[KIND_OVERFLOW]);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("event_stream_data_parser_top_tb passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, results_due.size());
      $display("event_stream_data_parser_top_tb failed");
    end
    $finish;
  end

endmodule
